// ===== hw/rtl/tsxd_pkg.sv =====
// package: constants and key table of the transport stream packet descrambler
`timescale 1ns / 1ps
package tsxd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 8;

  localparam logic [ByteW-1:0] SyncByte  = 8'h47;
  localparam logic [PosW-1:0]  PacketLen = 8'd188;
  localparam logic [PosW-1:0]  HeaderLen = 8'd4;
  localparam int unsigned      KeyLen    = 184;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [PosW-1:0]  pos_t;

  localparam byte_t KeyRom [KeyLen] = '{
    8'h6D, 8'h4E, 8'hF0, 8'h1E, 8'h59, 8'h8B, 8'hB2, 8'hF0,
    8'h31, 8'hF9, 8'hD0, 8'h85, 8'hDD, 8'h84, 8'h4A, 8'h6C,
    8'h15, 8'h1C, 8'h1C, 8'h0A, 8'h5B, 8'h61, 8'h6F, 8'h1A,
    8'hAD, 8'h60, 8'h46, 8'hF2, 8'hD5, 8'h03, 8'h91, 8'hC7,
    8'hB7, 8'hDE, 8'h68, 8'h9A, 8'h07, 8'h47, 8'h62, 8'h5E,
    8'h39, 8'hD6, 8'h7E, 8'h45, 8'h10, 8'h9D, 8'h1A, 8'hC4,
    8'h4C, 8'h7F, 8'hB7, 8'h03, 8'hCC, 8'hAD, 8'h72, 8'h6C,
    8'hE9, 8'h1B, 8'h85, 8'hA8, 8'hEE, 8'h4B, 8'hA9, 8'h3A,
    8'hFF, 8'hF1, 8'h3B, 8'h16, 8'hE0, 8'h59, 8'h4C, 8'h3A,
    8'hD5, 8'h4A, 8'h14, 8'h95, 8'h0A, 8'hD4, 8'h25, 8'h23,
    8'hF6, 8'h2F, 8'hE3, 8'h57, 8'h35, 8'hCE, 8'h52, 8'h84,
    8'h11, 8'hA3, 8'hCB, 8'h34, 8'hA7, 8'h15, 8'h60, 8'hE1,
    8'h98, 8'h71, 8'hF4, 8'h1F, 8'hF7, 8'hBD, 8'h22, 8'h4B,
    8'h61, 8'h8A, 8'hD6, 8'hAF, 8'h24, 8'h27, 8'hC3, 8'hA7,
    8'h07, 8'h9B, 8'hA5, 8'h57, 8'h83, 8'h80, 8'h58, 8'h07,
    8'h1D, 8'hDE, 8'h0A, 8'hD8, 8'hB9, 8'h0A, 8'hBE, 8'hAC,
    8'hA9, 8'h76, 8'h00, 8'h1C, 8'h23, 8'h9F, 8'h82, 8'h79,
    8'h41, 8'h56, 8'hC8, 8'h83, 8'hC3, 8'h38, 8'h37, 8'h4B,
    8'h5A, 8'hED, 8'hC9, 8'hD5, 8'hF2, 8'h87, 8'h02, 8'hC3,
    8'h79, 8'hA0, 8'h61, 8'hD9, 8'h63, 8'h50, 8'hCA, 8'h72,
    8'hC2, 8'h51, 8'h40, 8'h98, 8'hD9, 8'h8B, 8'hED, 8'hA9,
    8'hA1, 8'h4C, 8'hA5, 8'hE7, 8'hAF, 8'hF2, 8'h08, 8'h4D,
    8'h82, 8'hF8, 8'hD5, 8'h02, 8'h61, 8'hD8, 8'hC2, 8'hE1
  };

  // key byte for payload offset idx, zero past the table
  function automatic byte_t key_byte(input pos_t idx);
    byte_t k;
    k = '0;
    if (idx < PosW'(KeyLen)) begin
      k = KeyRom[idx];
    end
    return k;
  endfunction

endpackage

// ===== hw/rtl/tsxd_if.sv =====
// stream interfaces: raw byte input and descrambled result output
`timescale 1ns / 1ps
interface tsxd_in_if;
  logic                valid;
  logic                ready;
  tsxd_pkg::byte_t     in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tsxd_out_if;
  logic                valid;
  logic                ready;
  tsxd_pkg::byte_t     out_byte;
  logic                in_packet;
  logic                packet_start;
  logic                packet_end;

  modport source (output valid, output out_byte, output in_packet,
                  output packet_start, output packet_end, input ready);
  modport sink   (input valid, input out_byte, input in_packet,
                  input packet_start, input packet_end, output ready);
endinterface

// ===== hw/rtl/ts_packet_sync_xor_descrambler_unit.sv =====
// top level: transport stream packet sync and xor descrambler
// flow: each input byte is held in the input register and then in the result
//   register, which offers it; an output stall holds it in either register
// throughput: one byte per cycle while the output is not stalled, set by the
//   input and result register stages, each refilling in the cycle it drains
// reset: clears both stage valids and the packet state; the block starts
//   hunting for a sync byte
`timescale 1ns / 1ps
module ts_packet_sync_xor_descrambler_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  tsxd_in_if.sink           ts_in_i,
  tsxd_out_if.source        ts_out_o
);

  // input register stage
  logic                s1_valid_q;
  tsxd_pkg::byte_t     s1_byte_q;

  // result register stage
  logic                s2_valid_q;
  tsxd_pkg::byte_t     s2_byte_q;
  logic                s2_member_q;
  logic                s2_start_q;
  logic                s2_last_q;

  // packet state
  logic                sync_q, sync_d;
  tsxd_pkg::pos_t      pos_q, pos_d;

  tsxd_pkg::byte_t     res_byte;
  logic                res_member;
  logic                res_start;
  logic                res_last;

  logic                s2_adv;
  logic                s1_load;

  assign s2_adv  = s1_valid_q && (!s2_valid_q || ts_out_o.ready);
  assign s1_load = ts_in_i.valid && ts_in_i.ready;
  assign ts_in_i.ready = !s1_valid_q || s2_adv;

  always_comb begin
    res_byte   = s1_byte_q;
    res_member = 1'b0;
    res_start  = 1'b0;
    res_last   = 1'b0;
    sync_d     = sync_q;
    pos_d      = pos_q;
    if (!sync_q) begin
      if (s1_byte_q == tsxd_pkg::SyncByte) begin
        res_member = 1'b1;
        res_start  = 1'b1;
        sync_d     = 1'b1;
        pos_d      = tsxd_pkg::PosW'(1);
      end
    end else begin
      res_member = 1'b1;
      if (pos_q >= tsxd_pkg::HeaderLen && pos_q < tsxd_pkg::PacketLen) begin
        res_byte = s1_byte_q ^ tsxd_pkg::key_byte(pos_q - tsxd_pkg::HeaderLen);
      end
      // last byte of the packet, back to hunting
      if (pos_q >= tsxd_pkg::PacketLen - tsxd_pkg::PosW'(1)) begin
        res_last = 1'b1;
        sync_d   = 1'b0;
        pos_d    = '0;
      end else begin
        pos_d = pos_q + tsxd_pkg::PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      sync_q     <= 1'b0;
      pos_q      <= '0;
    end else begin
      if (ts_in_i.ready) begin
        s1_valid_q <= ts_in_i.valid;
      end
      if (s2_adv) begin
        s2_valid_q <= 1'b1;
        sync_q     <= sync_d;
        pos_q      <= pos_d;
      end else if (ts_out_o.ready) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_byte_q <= ts_in_i.in_byte;
    end
    if (s2_adv) begin
      s2_byte_q   <= res_byte;
      s2_member_q <= res_member;
      s2_start_q  <= res_start;
      s2_last_q   <= res_last;
    end
  end

  assign ts_out_o.valid        = s2_valid_q;
  assign ts_out_o.out_byte     = s2_byte_q;
  assign ts_out_o.in_packet    = s2_member_q;
  assign ts_out_o.packet_start = s2_start_q;
  assign ts_out_o.packet_end   = s2_last_q;

endmodule

// ===== hw/rtl/tsxd_checker.sv =====
// port-level checker for the descrambler and its bind to the top level
`timescale 1ns / 1ps
module tsxd_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  tsxd_pkg::byte_t   out_byte_i,
  input  logic              in_packet_i,
  input  logic              packet_start_i,
  input  logic              packet_end_i
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a packet opens only on the sync byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && packet_start_i |-> in_packet_i && out_byte_i == tsxd_pkg::SyncByte)
    else $error("packet start without sync byte");

  // skipped bytes carry no packet markers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !in_packet_i |-> !packet_start_i && !packet_end_i)
    else $error("packet marker on skipped byte");

  // a packet is never opened and closed by the same byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && packet_end_i |-> in_packet_i && !packet_start_i)
    else $error("bad packet end");

endmodule

bind ts_packet_sync_xor_descrambler_unit tsxd_checker u_tsxd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (ts_out_o.valid),
  .out_ready_i    (ts_out_o.ready),
  .out_byte_i     (ts_out_o.out_byte),
  .in_packet_i    (ts_out_o.in_packet),
  .packet_start_i (ts_out_o.packet_start),
  .packet_end_i   (ts_out_o.packet_end)
);

// ===== test/tb_top.sv =====
// testbench for the transport stream packet sync and xor descrambler
`timescale 1ns / 1ps
module tb_top;

  typedef struct packed {
    tsxd_pkg::byte_t out_byte;
    logic            in_packet;
    logic            packet_start;
    logic            packet_end;
  } ts_result_t;

  logic clk_i;
  logic rst_ni;

  tsxd_in_if  ts_in ();
  tsxd_out_if ts_out ();

  ts_packet_sync_xor_descrambler_unit DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ts_in_i  (ts_in),
    .ts_out_o (ts_out)
  );

  // descrambler state as the stream has moved it so far
  tsxd_pkg::pos_t pkt_pos;
  logic           pkt_synced;
  ts_result_t     expected_bytes_q [$];

  bit send_idle;
  bit recv_idle;
  int hold_cycles;
  int longest_hold;
  int n_bytes_in;
  int n_checked;
  int n_packets_done;
  int n_skipped;
  int n_errors;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  initial begin
    #400000;
    $display("timeout with %0d results still awaited", expected_bytes_q.size());
    $display("status: fail");
    $finish;
  end

  function automatic ts_result_t descramble_byte(input tsxd_pkg::byte_t b);
    ts_result_t r;
    r.out_byte     = b;
    r.in_packet    = 1'b0;
    r.packet_start = 1'b0;
    r.packet_end   = 1'b0;
    if (!pkt_synced) begin
      if (b == tsxd_pkg::SyncByte) begin
        r.in_packet    = 1'b1;
        r.packet_start = 1'b1;
        pkt_synced     = 1'b1;
        pkt_pos        = tsxd_pkg::pos_t'(1);
      end
    end else begin
      r.in_packet = 1'b1;
      if (pkt_pos >= tsxd_pkg::HeaderLen && pkt_pos < tsxd_pkg::PacketLen) begin
        r.out_byte = b ^ tsxd_pkg::KeyRom[int'(pkt_pos - tsxd_pkg::HeaderLen)];
      end
      if (pkt_pos >= tsxd_pkg::PacketLen - tsxd_pkg::pos_t'(1)) begin
        r.packet_end = 1'b1;
        pkt_synced   = 1'b0;
        pkt_pos      = '0;
      end else begin
        pkt_pos = pkt_pos + tsxd_pkg::pos_t'(1);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    n_errors++;
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
             n_checked, what, got, want);
  endtask

  // called right after a rising edge; returns at the edge of the transfer
  task automatic send_byte(input tsxd_pkg::byte_t b);
    int         gap;
    bit         took;
    ts_result_t exp_r;
    gap = send_idle ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      ts_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    ts_in.valid   <= 1'b1;
    ts_in.in_byte <= b;
    do begin
      @(negedge clk_i);
      took = ts_in.ready;
      @(posedge clk_i);
    end while (!took);
    exp_r = descramble_byte(b);
    expected_bytes_q.insert(expected_bytes_q.size(), exp_r);
    n_bytes_in++;
  endtask

  function automatic tsxd_pkg::byte_t pick_data();
    tsxd_pkg::byte_t b;
    case ($urandom_range(0, 9))
      0:       b = tsxd_pkg::SyncByte;
      1:       b = 8'h00;
      2:       b = 8'hFF;
      default: b = tsxd_pkg::byte_t'($urandom);
    endcase
    return b;
  endfunction

  function automatic tsxd_pkg::byte_t pick_noise();
    tsxd_pkg::byte_t b;
    do b = tsxd_pkg::byte_t'($urandom); while (b == tsxd_pkg::SyncByte);
    return b;
  endfunction

  task automatic finish_packet();
    while (pkt_synced) send_byte(pick_data());
  endtask

  // mostly clean packets with random payload, now and then raw junk
  task automatic send_stream(input int n_bytes);
    int stop_at;
    int n;
    stop_at = n_bytes_in + n_bytes;
    while (n_bytes_in < stop_at) begin
      if ($urandom_range(0, 4) != 0) begin
        n = $urandom_range(0, 3);
        repeat (n) send_byte(pick_noise());
        send_byte(tsxd_pkg::SyncByte);
        finish_packet();
      end else begin
        n = $urandom_range(1, 20);
        repeat (n) send_byte(tsxd_pkg::byte_t'($urandom));
        finish_packet();
      end
    end
  endtask

  // receiver: random stalls, optional long hold, checks every transfer
  initial begin
    ts_out.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      int         stall;
      bit         got_one;
      ts_result_t got;
      ts_result_t want;
      if (hold_cycles > 0) begin
        ts_out.ready <= 1'b0;
        if (hold_cycles > longest_hold) longest_hold = hold_cycles;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      stall = recv_idle ? $urandom_range(0, 3) : 0;
      repeat (stall) begin
        ts_out.ready <= 1'b0;
        @(posedge clk_i);
      end
      ts_out.ready <= 1'b1;
      do begin
        @(negedge clk_i);
        got_one = ts_out.valid;
        if (got_one) begin
          got = '{ts_out.out_byte, ts_out.in_packet, ts_out.packet_start,
                  ts_out.packet_end};
          if (expected_bytes_q.size() == 0) begin
            report_mismatch("unexpected transfer, out_byte", got.out_byte, 0);
          end else begin
            want = expected_bytes_q.pop_front();
            if (got.out_byte !== want.out_byte)
              report_mismatch("out_byte", got.out_byte, want.out_byte);
            if (got.in_packet !== want.in_packet)
              report_mismatch("in_packet", got.in_packet, want.in_packet);
            if (got.packet_start !== want.packet_start)
              report_mismatch("packet_start", got.packet_start, want.packet_start);
            if (got.packet_end !== want.packet_end)
              report_mismatch("packet_end", got.packet_end, want.packet_end);
            if (want.packet_end) n_packets_done++;
            if (!want.in_packet) n_skipped++;
          end
          n_checked++;
        end
        @(posedge clk_i);
      end while (!got_one);
    end
  end

  task automatic test_skipped_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h46);
    send_byte(8'h48);
    send_byte(8'hC7);
    send_byte(8'h07);
  endtask

  // sync values in the header and payload are plain data
  task automatic test_sync_inside_packet();
    send_byte(tsxd_pkg::SyncByte);
    send_byte(tsxd_pkg::SyncByte);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(tsxd_pkg::SyncByte);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    finish_packet();
    // sync straight after the last byte of a packet
    send_byte(tsxd_pkg::SyncByte);
    finish_packet();
  endtask

  task automatic test_random_idle();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    send_stream(600);
  endtask

  task automatic test_back_to_back();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_stream(250);
  endtask

  task automatic test_output_hold();
    send_idle   = 1'b0;
    recv_idle   = 1'b1;
    hold_cycles = 80;
    send_stream(150);
    send_idle   = 1'b1;
    hold_cycles = 40;
    send_stream(100);
  endtask

  // stream stops part way into a packet, so no end flag follows
  task automatic test_partial_packet();
    send_idle = 1'b1;
    send_byte(pick_noise());
    send_byte(tsxd_pkg::SyncByte);
    repeat (6) send_byte(pick_data());
  endtask

  initial begin
    rst_ni         = 1'b0;
    ts_in.valid   <= 1'b0;
    ts_in.in_byte <= '0;
    pkt_pos        = '0;
    pkt_synced     = 1'b0;
    send_idle      = 1'b1;
    recv_idle      = 1'b1;
    hold_cycles    = 0;
    longest_hold   = 0;
    n_bytes_in     = 0;
    n_checked      = 0;
    n_packets_done = 0;
    n_skipped      = 0;
    n_errors       = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_skipped_bytes();
    test_sync_inside_packet();
    test_random_idle();
    test_back_to_back();
    test_output_hold();
    test_partial_packet();

    ts_in.valid <= 1'b0;
    while (expected_bytes_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("sent %0d bytes, checked %0d results: %0d full packets, %0d skipped bytes",
             n_bytes_in, n_checked, n_packets_done, n_skipped);
    $display("longest output hold %0d cycles, %0d mismatches", longest_hold, n_errors);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
